@@ hw/rtl/lgfe_pkg.sv @@
// Package: shared types, codes and helpers for the LED gradient fade engine.
package lgfe_pkg;

    localparam int NumLeds = 1024;
    localparam int AddrW   = $clog2(NumLeds);

    // Reciprocals for a divide by 100: x / 100 = (x * mul) >> shift.
    localparam logic [31:0] Div100Mul32 = 32'h51EB_851F;  // any 32-bit x, shift 37
    localparam logic [12:0] Div100Mul16 = 13'd5243;       // x below 43690, shift 19

    typedef enum logic [2:0] {
        KIND_STEP  = 3'd0,
        KIND_TICK  = 3'd1,
        KIND_RESET = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CFG_FIRST = 3'd0,
        CFG_LAST  = 3'd1,
        CFG_START = 3'd2,
        CFG_END   = 3'd3,
        CFG_SKIP  = 3'd4,
        CFG_KEEP  = 3'd5,
        CFG_FADE  = 3'd6
    } cfg_idx_t;

    localparam logic [2:0] PH_HOME  = 3'd0;
    localparam logic [2:0] PH_FILL0 = 3'd1;
    localparam logic [2:0] PH_FILL  = 3'd2;
    localparam logic [2:0] PH_FADE0 = 3'd3;
    localparam logic [2:0] PH_FADE  = 3'd4;
    localparam logic [2:0] PH_WAIT  = 3'd5;

    localparam logic [1:0] SEG_FREE = 2'd0;
    localparam logic [1:0] SEG_BUSY = 2'd1;
    localparam logic [1:0] SEG_DONE = 2'd2;

    // Sequencer states of the control unit.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_DIV,
        ST_RD,
        ST_MUL,
        ST_MOD,
        ST_BLEND,
        ST_WB,
        ST_READ,
        ST_OUT
    } st_t;

    // Byte select of a packed RGBW word, channel 0 = red.
    function automatic logic [7:0] chan8(input logic [31:0] w, input logic [1:0] c);
        chan8 = w[8*(3-c) +: 8];
    endfunction

endpackage

@@ hw/rtl/lgfe_ram.sv @@
// Single-port synchronous RAM with a registered read.
module lgfe_ram #(
    parameter int Depth = 1024,
    parameter int Width = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ hw/rtl/lgfe_div.sv @@
// Restoring divider, one quotient bit per cycle.
module lgfe_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    import lgfe_pkg::*;

    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[31]} - {1'b0, d_reg};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = busy_reg && (cnt_reg == 6'd1);
    assign quotient  = q_next;
    assign remainder = r_next;
endmodule

@@ hw/rtl/led_gradient_fade_engine.sv @@
// Top level: LED gradient fade engine with LED and copy memories.
//
// Usage: configuration registers are written through cfg_we/cfg_index/cfg_data
// while the block is idle. Items arrive on s_valid/s_ready with kind, led_index
// and led_value; each item gives exactly one result beat on m_valid/m_ready.
// Tick, reset, home and waiting steps go straight to the output register; a write
// passes ST_WB first, a read ST_READ. A step that writes an LED walks four
// channels, each a read, a divide for k*delta/N, a divide for the skip test,
// the blend (with an extra multiply step when fading) and a write-back, then
// reads the word back. The first fade step adds the segment copy, a read and a
// write per LED through single-port memories, and the tick interval. One item is
// in work at a time; a new one is taken only once the last result has gone out.
// Reset: aresetn (synchronous, active low) clears the control state, then a
// clearing pass zeroes the LED memory, one entry a cycle, while s_ready stays
// low. The copy memory is not cleared.
// Stall: the result sits in an output register until m_ready; s_ready is low
// until then.
module led_gradient_fade_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [9:0]  s_led_index,
    input  logic [31:0] s_led_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_seg_status,
    output logic [2:0]  m_phase,
    output logic        m_value_valid,
    output logic [9:0]  m_out_index,
    output logic [31:0] m_out_value
);
    import lgfe_pkg::*;

    // configuration
    logic [9:0]  first_reg, last_reg;
    logic [31:0] startc_reg, endc_reg, fade_reg;
    logic [7:0]  skip_reg;
    logic        keep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= '0; last_reg <= '0; startc_reg <= '0; endc_reg <= '0;
            skip_reg <= 8'd1; keep_reg <= 1'b0; fade_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FIRST: first_reg  <= cfg_data[9:0];
                CFG_LAST:  last_reg   <= cfg_data[9:0];
                CFG_START: startc_reg <= cfg_data;
                CFG_END:   endc_reg   <= cfg_data;
                CFG_SKIP:  skip_reg   <= cfg_data[7:0];
                CFG_KEEP:  keep_reg   <= cfg_data[0];
                CFG_FADE:  fade_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // memories
    logic        led_we, cp_we;
    logic [9:0]  led_addr, cp_addr;
    logic [31:0] led_wdata, led_rdata, cp_rdata;

    lgfe_ram #(.Depth(NumLeds), .Width(32)) u_led (
        .aclk(aclk), .we(led_we), .addr(led_addr), .wdata(led_wdata), .rdata(led_rdata));
    lgfe_ram #(.Depth(NumLeds), .Width(32)) u_copy (
        .aclk(aclk), .we(cp_we), .addr(cp_addr), .wdata(led_rdata), .rdata(cp_rdata));

    // divider
    logic        div_start, div_done;
    logic [31:0] div_a, div_b, div_q, div_r;
    lgfe_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r));

    // engine state
    st_t         st_reg, st_next;
    logic [2:0]  ph_reg, ph_next;
    logic [1:0]  seg_reg, seg_next;
    logic [9:0]  up_reg, up_next, dn_reg, dn_next;
    logic [10:0] cnt_reg, cnt_next;
    logic [31:0] dlt_reg, dlt_next;
    logic [3:0]  desc_reg, desc_next;
    logic [6:0]  int_reg, int_next;
    logic [31:0] el_reg, el_next, ti_reg, ti_next;
    logic [10:0] sw_reg, sw_next;          // sweep counter (clear / copy)
    logic [1:0]  ch_reg, ch_next;          // channel in work
    logic        dphase_reg, dphase_next;  // 0: start a multi-cycle step, 1: finish it
    logic [7:0]  tgt_reg, tgt_next;
    logic [7:0]  cpv_reg, cpv_next;
    logic        dneg_reg, dneg_next;
    logic        skp_reg, skp_next;        // position not on the skip grid
    logic [15:0] prod_reg, prod_next;      // intensity * |target - copy|
    logic [31:0] word_reg, word_next;
    logic        fading_reg, fading_next;
    logic [9:0]  redpos_reg, redpos_next;
    logic [2:0]  kind_reg, kind_next;
    logic [9:0]  idx_reg, idx_next;
    logic [31:0] val_reg, val_next;
    logic        mv_reg, mv_next;
    logic [1:0]  os_reg, os_next;
    logic [2:0]  op_reg, op_next;
    logic        ov_reg, ov_next;
    logic [9:0]  oi_reg, oi_next;
    logic [31:0] ow_reg, ow_next;

    // per-channel helpers
    logic [9:0]  pos;
    logic [7:0]  ca, cb, lowest, dc;
    logic [9:0]  k;
    logic [7:0]  step;
    logic [10:0] nn;
    logic [8:0]  mag;
    logic [15:0] prod;
    logic [28:0] blend_mul;
    logic [7:0]  blend_q;
    logic [63:0] fade_mul;
    logic [10:0] nxt_up;
    logic [9:0]  copy_addr;

    always_comb begin
        pos     = desc_reg[3-ch_reg] ? dn_reg : up_reg;
        ca      = chan8(startc_reg, ch_reg);
        cb      = chan8(endc_reg, ch_reg);
        lowest  = (ca <= cb) ? ca : cb;
        dc      = chan8(dlt_reg, ch_reg);
        k       = up_reg - first_reg;
        step    = (skip_reg == 8'd0) ? 8'd1 : skip_reg;
        nn      = (cnt_reg == 11'd0) ? 11'd1 : cnt_reg;
        mag     = (cpv_reg > tgt_reg) ? ({1'b0, cpv_reg} - {1'b0, tgt_reg})
                                      : ({1'b0, tgt_reg} - {1'b0, cpv_reg});
        prod    = {9'd0, int_reg} * {7'd0, mag};
        // blend magnitude / 100, truncated
        blend_mul = {13'd0, prod_reg} * {16'd0, Div100Mul16};
        blend_q   = blend_mul[26:19];
        // fade interval = fade_ticks / 100
        fade_mul  = {32'd0, fade_reg} * {32'd0, Div100Mul32};
        nxt_up  = {1'b0, up_reg} + 11'd1;
        copy_addr = first_reg + sw_reg[9:0];
    end

    always_comb begin
        st_next = st_reg; ph_next = ph_reg; seg_next = seg_reg;
        up_next = up_reg; dn_next = dn_reg; cnt_next = cnt_reg;
        dlt_next = dlt_reg; desc_next = desc_reg; int_next = int_reg;
        el_next = el_reg; ti_next = ti_reg; sw_next = sw_reg; ch_next = ch_reg;
        dphase_next = dphase_reg; tgt_next = tgt_reg; cpv_next = cpv_reg;
        dneg_next = dneg_reg; skp_next = skp_reg; prod_next = prod_reg;
        word_next = word_reg; fading_next = fading_reg;
        redpos_next = redpos_reg; kind_next = kind_reg; idx_next = idx_reg;
        val_next = val_reg; mv_next = mv_reg; os_next = os_reg; op_next = op_reg;
        ov_next = ov_reg; oi_next = oi_reg; ow_next = ow_reg;
        led_we = 1'b0; led_addr = pos; led_wdata = word_reg;
        cp_we = 1'b0; cp_addr = pos;
        div_start = 1'b0; div_a = '0; div_b = '0;
        s_ready = 1'b0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (st_reg)
            ST_CLEAR: begin
                led_we = 1'b1; led_addr = sw_reg[9:0]; led_wdata = '0;
                sw_next = sw_reg + 11'd1;
                if (sw_reg == 11'(NumLeds - 1)) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = !mv_reg;
                if (s_valid && !mv_reg) begin
                    kind_next = s_kind; idx_next = s_led_index; val_next = s_led_value;
                    ov_next = 1'b0; oi_next = '0; ow_next = '0;
                    st_next = ST_OUT;
                    case (s_kind)
                        KIND_TICK:  el_next = el_reg + 32'd1;
                        KIND_RESET: begin seg_next = SEG_FREE; ph_next = PH_HOME; end
                        KIND_WRITE: st_next = ST_WB;
                        KIND_READ:  st_next = ST_READ;
                        KIND_STEP: begin
                            if (seg_reg != SEG_DONE) begin
                                case (ph_reg)
                                    PH_HOME: begin
                                        for (int c = 0; c < 4; c++) begin
                                            dlt_next[8*(3-c) +: 8] =
                                                (chan8(startc_reg, 2'(c)) <= chan8(endc_reg, 2'(c)))
                                                ? chan8(endc_reg, 2'(c)) - chan8(startc_reg, 2'(c))
                                                : chan8(startc_reg, 2'(c)) - chan8(endc_reg, 2'(c));
                                            desc_next[3-c] =
                                                chan8(startc_reg, 2'(c)) > chan8(endc_reg, 2'(c));
                                        end
                                        cnt_next = {1'b0, last_reg} - {1'b0, first_reg} + 11'd1;
                                        up_next = first_reg; dn_next = last_reg;
                                        ph_next = (fade_reg != 0) ? PH_FADE0 : PH_FILL0;
                                        el_next = '0; seg_next = SEG_BUSY;
                                    end
                                    PH_FILL0, PH_FILL: begin
                                        ph_next = PH_FILL; fading_next = 1'b0;
                                        ch_next = '0; st_next = ST_RD;
                                    end
                                    PH_FADE0: begin
                                        sw_next = '0; fading_next = 1'b1;
                                        st_next = (cnt_reg == 0) ? ST_DIV : ST_COPY_RD;
                                    end
                                    PH_FADE: begin
                                        fading_next = 1'b1; ch_next = '0; st_next = ST_RD;
                                    end
                                    PH_WAIT: begin
                                        if (el_reg > ti_reg) begin
                                            el_next = el_reg - ti_reg;
                                            int_next = int_reg + 7'd1;
                                            ph_next = PH_FADE;
                                            up_next = first_reg; dn_next = last_reg;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_COPY_RD: begin
                led_addr = copy_addr; st_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                cp_we = 1'b1; cp_addr = copy_addr;
                sw_next = sw_reg + 11'd1;
                st_next = (sw_reg + 11'd1 == cnt_reg) ? ST_DIV : ST_COPY_RD;
            end
            ST_DIV: begin
                // fade interval by reciprocal multiply
                ti_next = {5'd0, fade_mul[63:37]}; int_next = '0; ph_next = PH_FADE;
                ch_next = '0; st_next = ST_RD;
            end
            ST_RD: begin
                // read LED and copy word at this channel's position
                led_addr = pos; cp_addr = pos;
                if (ch_reg == 2'd0) begin
                    redpos_next = pos;
                end
                st_next = ST_MUL;
            end
            ST_MUL: begin
                led_addr = pos; cp_addr = pos;
                word_next = led_rdata;
                cpv_next = chan8(cp_rdata, ch_reg);
                div_a = {22'd0, k} * {24'd0, dc};
                div_b = {21'd0, nn};
                if (!dphase_reg) begin
                    div_start = 1'b1; dphase_next = 1'b1;
                end else if (div_done) begin
                    tgt_next = lowest + div_q[7:0];
                    dphase_next = 1'b0;
                    st_next = ST_MOD;
                end
            end
            ST_MOD: begin
                // skip test: remainder of position / skip step
                div_a = {22'd0, pos};
                div_b = {24'd0, step};
                if (!dphase_reg) begin
                    div_start = 1'b1; dphase_next = 1'b1;
                end else if (div_done) begin
                    skp_next = (div_r[7:0] != 8'd0);
                    dphase_next = 1'b0;
                    st_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (skp_reg) begin
                    if (!keep_reg) word_next[8*(3-ch_reg) +: 8] = 8'd0;
                    st_next = ST_WB;
                end else if (!fading_reg) begin
                    word_next[8*(3-ch_reg) +: 8] = tgt_reg;
                    st_next = ST_WB;
                end else if (!dphase_reg) begin
                    dneg_next = (cpv_reg > tgt_reg);
                    prod_next = prod;
                    dphase_next = 1'b1;
                end else begin
                    word_next[8*(3-ch_reg) +: 8] = dneg_reg ? cpv_reg - blend_q
                                                            : cpv_reg + blend_q;
                    dphase_next = 1'b0; st_next = ST_WB;
                end
            end
            ST_WB: begin
                led_we = 1'b1;
                if (kind_reg == KIND_WRITE) begin
                    led_addr = idx_reg; led_wdata = val_reg; st_next = ST_OUT;
                end else begin
                    led_addr = pos; led_wdata = word_reg;
                    if (ch_reg == 2'd3) begin
                        dn_next = dn_reg - 10'd1;
                        up_next = nxt_up[9:0];
                        if (nxt_up > {1'b0, last_reg}) begin
                            if (!fading_reg || int_reg == 7'd100) begin
                                ph_next = PH_HOME; seg_next = SEG_DONE;
                            end else begin
                                ph_next = PH_WAIT;
                            end
                        end
                        st_next = ST_READ;
                    end else begin
                        ch_next = ch_reg + 2'd1; st_next = ST_RD;
                    end
                end
            end
            ST_READ: begin
                // report stored word after the update or for a read
                led_addr = (kind_reg == KIND_READ) ? idx_reg : redpos_reg;
                oi_next = led_addr; ov_next = 1'b1;
                st_next = ST_OUT;
                dphase_next = 1'b1;
                if (dphase_reg) begin
                    ow_next = led_rdata; dphase_next = 1'b0;
                    st_next = ST_OUT;
                end else begin
                    st_next = ST_READ;
                end
            end
            ST_OUT: begin
                mv_next = 1'b1; os_next = seg_next; op_next = ph_next;
                os_next = seg_reg; op_next = ph_reg;
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLEAR; ph_reg <= PH_HOME; seg_reg <= SEG_FREE;
            up_reg <= '0; dn_reg <= '0; cnt_reg <= '0; dlt_reg <= '0; desc_reg <= '0;
            int_reg <= '0; el_reg <= '0; ti_reg <= '0; sw_reg <= '0; ch_reg <= '0;
            dphase_reg <= 1'b0; mv_reg <= 1'b0; fading_reg <= 1'b0;
        end else begin
            st_reg <= st_next; ph_reg <= ph_next; seg_reg <= seg_next;
            up_reg <= up_next; dn_reg <= dn_next; cnt_reg <= cnt_next;
            dlt_reg <= dlt_next; desc_reg <= desc_next; int_reg <= int_next;
            el_reg <= el_next; ti_reg <= ti_next; sw_reg <= sw_next; ch_reg <= ch_next;
            dphase_reg <= dphase_next; mv_reg <= mv_next; fading_reg <= fading_next;
        end
        tgt_reg <= tgt_next; cpv_reg <= cpv_next; dneg_reg <= dneg_next;
        skp_reg <= skp_next; prod_reg <= prod_next;
        word_reg <= word_next; redpos_reg <= redpos_next; kind_reg <= kind_next;
        idx_reg <= idx_next; val_reg <= val_next; os_reg <= os_next; op_reg <= op_next;
        ov_reg <= ov_next; oi_reg <= oi_next; ow_reg <= ow_next;
    end

    assign m_valid       = mv_reg;
    assign m_seg_status  = os_reg;
    assign m_phase       = op_reg;
    assign m_value_valid = ov_reg;
    assign m_out_index   = oi_reg;
    assign m_out_value   = ow_reg;
endmodule

@@ test/tb_led_gradient_fade_engine.sv @@
// Testbench for the LED gradient fade engine: random items checked against a local prediction.
module tb_led_gradient_fade_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import lgfe_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  phase;
        logic        vvalid;
        logic [9:0]  idx;
        logic [31:0] value;
    } fade_beat_t;

    // Tracks the segment engine and holds the results it should produce.
    class fade_tracker;
        bit [31:0] leds[NumLeds];
        bit [31:0] copies[NumLeds];
        bit [2:0]  ph;
        bit [1:0]  seg;
        bit [9:0]  up_i, down_i;
        bit [10:0] cnt;
        bit [31:0] deltas;
        bit [3:0]  desc;
        bit [6:0]  inten;
        bit [31:0] elapsed, interval;
        bit [9:0]  first, last;
        bit [31:0] col_a, col_b, fade;
        bit [7:0]  skip;
        bit        keep;
        fade_beat_t expected_beats[$];
        int        errors;
        int        results;

        function new();
            foreach (leds[i]) begin
                leds[i] = 0;
                copies[i] = 0;
            end
            ph = PH_HOME; seg = SEG_FREE; up_i = 0; down_i = 0; cnt = 0;
            deltas = 0; desc = 0; inten = 0; elapsed = 0; interval = 0;
            first = 0; last = 0; col_a = 0; col_b = 0; fade = 0; skip = 1; keep = 0;
            errors = 0; results = 0;
        endfunction

        function bit [7:0] byte_of(bit [31:0] w, int c);
            return w[8*(3-c) +: 8];
        endfunction

        function void set_reg(cfg_idx_t r, bit [31:0] d);
            case (r)
                CFG_FIRST: first = d[9:0];
                CFG_LAST:  last = d[9:0];
                CFG_START: col_a = d;
                CFG_END:   col_b = d;
                CFG_SKIP:  skip = d[7:0];
                CFG_KEEP:  keep = d[0];
                CFG_FADE:  fade = d;
                default: ;
            endcase
        endfunction

        // One LED of a fill or fade pass; returns where red went.
        function bit [9:0] paint(bit fading);
            bit [9:0] k, pos, red_pos;
            int unsigned stepv, a, b, lowest, n, target, v, nxt;
            int cp, diff;
            k = up_i - first;
            stepv = (skip != 0) ? skip : 1;
            red_pos = 0;
            for (int c = 0; c < 4; c++) begin
                pos = desc[c] ? down_i : up_i;
                a = byte_of(col_a, c);
                b = byte_of(col_b, c);
                lowest = (a <= b) ? a : b;
                n = (cnt != 0) ? cnt : 1;
                target = lowest + k * byte_of(deltas, c) / n;
                if (c == 0) red_pos = pos;
                if (pos % stepv != 0) begin
                    v = keep ? byte_of(leds[pos], c) : 0;
                end else if (fading) begin
                    cp = byte_of(copies[pos], c);
                    diff = int'(target) - cp;
                    v = cp + diff * int'(inten) / 100;
                end else begin
                    v = target;
                end
                leds[pos][8*(3-c) +: 8] = v[7:0];
            end
            down_i = down_i - 1;
            nxt = up_i + 1;
            up_i = nxt[9:0];
            if (nxt > last) begin
                if (!fading || inten == 100) begin
                    ph = PH_HOME;
                    seg = SEG_DONE;
                end else begin
                    ph = PH_WAIT;
                end
            end
            return red_pos;
        endfunction

        function void note_item(bit [2:0] kind, bit [9:0] idx, bit [31:0] val);
            fade_beat_t e;
            bit [7:0] a, b;
            e = '0;
            if (kind == KIND_STEP && seg != SEG_DONE) begin
                if (ph == PH_HOME) begin
                    deltas = 0;
                    desc = 0;
                    for (int c = 0; c < 4; c++) begin
                        a = byte_of(col_a, c);
                        b = byte_of(col_b, c);
                        deltas[8*(3-c) +: 8] = (a <= b) ? b - a : a - b;
                        desc[c] = a > b;
                    end
                    cnt = {1'b0, last} - {1'b0, first} + 11'd1;
                    up_i = first;
                    down_i = last;
                    ph = (fade > 0) ? PH_FADE0 : PH_FILL0;
                    elapsed = 0;
                    seg = SEG_BUSY;
                end else if (ph == PH_FILL0 || ph == PH_FILL) begin
                    ph = PH_FILL;
                    e.idx = paint(0);
                    e.vvalid = 1;
                end else if (ph == PH_FADE0 || ph == PH_FADE) begin
                    if (ph == PH_FADE0) begin
                        for (int i = 0; i < cnt; i++)
                            copies[(first + i) % NumLeds] = leds[(first + i) % NumLeds];
                        interval = fade / 100;
                        inten = 0;
                        ph = PH_FADE;
                    end
                    e.idx = paint(1);
                    e.vvalid = 1;
                end else if (ph == PH_WAIT) begin
                    if (elapsed > interval) begin
                        elapsed = elapsed - interval;
                        inten = inten + 1;
                        ph = PH_FADE;
                        up_i = first;
                        down_i = last;
                    end
                end
                if (e.vvalid) e.value = leds[e.idx];
            end else if (kind == KIND_TICK) begin
                elapsed = elapsed + 1;
            end else if (kind == KIND_RESET) begin
                seg = SEG_FREE;
                ph = PH_HOME;
            end else if (kind == KIND_WRITE) begin
                leds[idx] = val;
            end else if (kind == KIND_READ) begin
                e.vvalid = 1;
                e.idx = idx;
                e.value = leds[idx];
            end
            e.status = seg;
            e.phase = ph;
            expected_beats.push_back(e);
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(fade_beat_t got);
            fade_beat_t w;
            results++;
            if (expected_beats.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            w = expected_beats.pop_front();
            if (got.status !== w.status)
                report($sformatf("seg_status %0d, want %0d", got.status, w.status));
            if (got.phase !== w.phase)
                report($sformatf("phase %0d, want %0d", got.phase, w.phase));
            if (got.vvalid !== w.vvalid)
                report($sformatf("value_valid %0d, want %0d", got.vvalid, w.vvalid));
            if (got.idx !== w.idx)
                report($sformatf("out_index %0d, want %0d", got.idx, w.idx));
            if (got.value !== w.value)
                report($sformatf("out_value %h, want %h", got.value, w.value));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [2:0]  s_kind = '0;
    logic [9:0]  s_led_index = '0;
    logic [31:0] s_led_value = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_seg_status;
    logic [2:0]  m_phase;
    logic        m_value_valid;
    logic [9:0]  m_out_index;
    logic [31:0] m_out_value;

    fade_tracker tracker = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_left = 0;
    bit held = 0;

    led_gradient_fade_engine u_top (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    initial begin
        #100ms;
        $display("tb_led_gradient_fade_engine failed");
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                tracker.check_result({m_seg_status, m_phase, m_value_valid,
                                      m_out_index, m_out_value});
            @(negedge aclk);
            if (!held && tracker.results == 400) begin
                held = 1;
                hold_left = 3000;
            end
            if (hold_left > 0) begin
                m_ready = 0;
                hold_left--;
            end else begin
                m_ready = ($urandom % 100) >= recv_idle;
            end
        end
    end

    // Offer one beat; entered and left at a falling edge, valid left high.
    task send_item(bit [2:0] kind, bit [9:0] idx, bit [31:0] val);
        if (($urandom % 100) < send_idle) begin
            s_valid = 0;
            do @(negedge aclk); while (($urandom % 100) < send_idle);
        end
        s_valid = 1;
        s_kind = kind;
        s_led_index = idx;
        s_led_value = val;
        do @(posedge aclk); while (!s_ready);
        tracker.note_item(kind, idx, val);
        @(negedge aclk);
    endtask

    task drain();
        s_valid = 0;
        while (tracker.expected_beats.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task write_reg(cfg_idx_t r, bit [31:0] d);
        cfg_we = 1;
        cfg_index = r;
        cfg_data = d;
        @(negedge aclk);
        cfg_we = 0;
        tracker.set_reg(r, d);
    endtask

    task set_segment(bit [9:0] f, bit [9:0] l, bit [31:0] a, bit [31:0] b,
                     bit [7:0] sk, bit kp, bit [31:0] fd);
        write_reg(CFG_FIRST, f);
        write_reg(CFG_LAST, l);
        write_reg(CFG_START, a);
        write_reg(CFG_END, b);
        write_reg(CFG_SKIP, sk);
        write_reg(CFG_KEEP, kp);
        write_reg(CFG_FADE, fd);
    endtask

    // Random item: mostly steps and ticks, some memory traffic and noise.
    task random_item();
        int r;
        bit [2:0] kind;
        r = $urandom % 100;
        if (r < 55)      kind = KIND_STEP;
        else if (r < 80) kind = KIND_TICK;
        else if (r < 87) kind = KIND_WRITE;
        else if (r < 94) kind = KIND_READ;
        else if (r < 97) kind = KIND_RESET;
        else             kind = 3'($urandom_range(5, 7));
        send_item(kind, 10'($urandom), $urandom);
    endtask

    initial begin
        bit [9:0] f, l;
        bit [31:0] fd;
        repeat (3) @(negedge aclk);
        aresetn = 1;

        // Directed: memory extremes, unknown kind, descending fill with skips.
        send_item(KIND_WRITE, 10'd0, 32'hFFFF_FFFF);
        send_item(KIND_WRITE, 10'd1023, 32'h0123_4567);
        send_item(KIND_READ, 10'd0, 32'h0);
        send_item(KIND_READ, 10'd1023, 32'hFFFF_FFFF);
        send_item(KIND_READ, 10'd500, 32'h0);
        send_item(3'd7, 10'd1023, 32'hFFFF_FFFF);
        send_item(KIND_TICK, 10'd0, 32'h0);
        drain();
        set_segment(10'd1020, 10'd1023, 32'hFF00_FF00, 32'h00FF_00FF, 8'd2, 1'b1, 32'd0);
        repeat (6) send_item(KIND_STEP, 10'd0, 32'h0);
        send_item(KIND_RESET, 10'd0, 32'h0);
        drain();
        // Last below first, zero skip step, short fade.
        set_segment(10'd5, 10'd3, 32'h1234_5678, 32'h8765_4321, 8'd0, 1'b0, 32'd1);
        repeat (4) send_item(KIND_STEP, 10'd0, 32'h0);
        send_item(KIND_TICK, 10'd0, 32'h0);
        send_item(KIND_TICK, 10'd0, 32'h0);
        repeat (3) send_item(KIND_STEP, 10'd0, 32'h0);
        send_item(KIND_RESET, 10'd0, 32'h0);
        drain();

        // Random phases with varying settings and idling profiles.
        for (int p = 0; p < 8; p++) begin
            if (p < 3) begin
                send_idle = 33; recv_idle = 57;
            end else if (p < 6) begin
                send_idle = 57; recv_idle = 33;
            end else begin
                send_idle = 0; recv_idle = 0;
            end
            f = 10'($urandom);
            l = (f > 1016) ? 10'd1023 : f + 10'($urandom_range(0, 6));
            fd = ($urandom % 2) ? 32'd0 : $urandom_range(1, 400);
            if (p == 2) begin
                f = 10'd0; l = 10'd1023; fd = 0;
            end
            if (p == 4) fd = 32'hFFFF_FFFF;
            if (p == 5) begin
                f = 10'd900; l = 10'd899;
            end
            set_segment(f, l, $urandom, $urandom, 8'($urandom_range(0, 5)),
                        1'($urandom), fd);
            if (p == 7) set_segment(f, l, 32'h0, 32'hFFFF_FFFF, 8'd255, 1'b1, fd);
            send_item(KIND_RESET, 10'd0, 32'h0);
            repeat (135) random_item();
            drain();
        end

        repeat (300) @(negedge aclk);
        if (tracker.errors == 0 && tracker.expected_beats.size() == 0)
            $display("tb_led_gradient_fade_engine passed");
        else
            $display("tb_led_gradient_fade_engine failed");
        $finish;
    end
endmodule
